[src/rfr_pkg.sv]
package rfr_pkg;

   localparam logic [7:0] START_FIRST = 8'hAA;
   localparam logic [7:0] START_SECOND = 8'h55;
   localparam logic [15:0] START_SUM = 16'h00FF;
   localparam logic [8:0] HEADER_LEN = 9'd5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   localparam logic [7:0] CTRL_REGISTER = 8'h00;
   localparam logic [7:0] CTRL_INFO = 8'h01;
   localparam logic [7:0] FUNC_REG_REQUEST = 8'h80;
   localparam logic [7:0] FUNC_REG_CONFIRM = 8'h81;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_FINISHED = 2'd1,
      EV_ABORTED = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_REG_REQUEST = 2'd1,
      CLASS_REG_CONFIRM = 2'd2,
      CLASS_INFO_REPLY = 2'd3
   } class_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      logic kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      event_type event_res;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] source_addr;
      logic [7:0] dest_addr;
      logic [7:0] control_code;
      logic [7:0] function_code;
      logic [7:0] data_length;
      logic checksum_ok;
      class_type message_class;
   } result_type;

   function automatic class_type classify(input logic [7:0] ctrl, input logic [7:0] func);
      class_type cls;
      cls = CLASS_OTHER;
      if (ctrl == CTRL_REGISTER && func == FUNC_REG_REQUEST) begin
         cls = CLASS_REG_REQUEST;
      end else if (ctrl == CTRL_REGISTER && func == FUNC_REG_CONFIRM) begin
         cls = CLASS_REG_CONFIRM;
      end else if (ctrl == CTRL_INFO && func == FUNC_REG_CONFIRM) begin
         cls = CLASS_INFO_REPLY;
      end
      return cls;
   endfunction

endpackage

[src/rfr_in_stage.sv]
module rfr_in_stage (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic advance,
   output logic item_valid,
   output rfr_pkg::item_type item
);

   logic valid_ff, valid_in;
   rfr_pkg::item_type item_ff, item_in;
   logic take;

   assign req_ready = !valid_ff || advance;
   assign take = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in.kind = req_kind;
         item_in.rx_byte = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

[src/rfr_core.sv]
module rfr_core (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  rfr_pkg::item_type item,
   input  logic [15:0] timeout_ticks,
   output logic res_valid,
   output rfr_pkg::result_type res
);

   logic in_frame_ff, in_frame_in;
   logic [7:0] previous_byte_ff, previous_byte_in;
   logic [8:0] bytes_taken_ff, bytes_taken_in;
   logic [8:0] bytes_remaining_ff, bytes_remaining_in;
   logic [7:0] header_ff [5];
   logic [7:0] header_in [5];
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0] sum_high_ff, sum_high_in;
   logic [15:0] idle_count_ff, idle_count_in;

   logic [16:0] idle_next;
   logic [8:0] payload_pos;
   logic [7:0] b;
   logic sum_ok;

   assign b = item.rx_byte;
   assign idle_next = {1'b0, idle_count_ff} + 17'd1;
   assign payload_pos = bytes_taken_ff - rfr_pkg::HEADER_LEN;
   assign sum_ok = (sum_high_ff == running_sum_ff[15:8]) && (b == running_sum_ff[7:0]);

   always_comb begin
      in_frame_in = in_frame_ff;
      previous_byte_in = previous_byte_ff;
      bytes_taken_in = bytes_taken_ff;
      bytes_remaining_in = bytes_remaining_ff;
      header_in = header_ff;
      running_sum_in = running_sum_ff;
      sum_high_in = sum_high_ff;
      idle_count_in = idle_count_ff;
      res_valid = 1'b0;
      res = '0;

      if (advance) begin
         if (item.kind == rfr_pkg::KIND_TICK) begin
            if (in_frame_ff) begin
               if (idle_next > {1'b0, timeout_ticks}) begin
                  in_frame_in = 1'b0;
                  idle_count_in = '0;
                  res_valid = 1'b1;
                  res.event_res = rfr_pkg::EV_ABORTED;
               end else begin
                  idle_count_in = idle_next[15:0];
               end
            end
         end else begin
            idle_count_in = '0;
            if (!in_frame_ff) begin
               if (previous_byte_ff == rfr_pkg::START_FIRST && b == rfr_pkg::START_SECOND) begin
                  in_frame_in = 1'b1;
                  bytes_taken_in = '0;
                  bytes_remaining_in = '0;
                  previous_byte_in = '0;
                  running_sum_in = rfr_pkg::START_SUM;
               end else begin
                  previous_byte_in = b;
               end
            end else if (bytes_taken_ff < rfr_pkg::HEADER_LEN) begin
               header_in[bytes_taken_ff[2:0]] = b;
               running_sum_in = running_sum_ff + {8'd0, b};
               bytes_taken_in = bytes_taken_ff + 9'd1;
               if (bytes_taken_ff == rfr_pkg::HEADER_LEN - 9'd1) begin
                  bytes_remaining_in = {1'b0, b} + 9'd2;
               end
            end else if (bytes_remaining_ff > 9'd2) begin
               res_valid = 1'b1;
               res.event_res = rfr_pkg::EV_PAYLOAD;
               res.payload_byte = b;
               res.payload_index = payload_pos[7:0];
               running_sum_in = running_sum_ff + {8'd0, b};
               bytes_taken_in = bytes_taken_ff + 9'd1;
               bytes_remaining_in = bytes_remaining_ff - 9'd1;
            end else if (bytes_remaining_ff == 9'd2) begin
               sum_high_in = b;
               bytes_remaining_in = 9'd1;
            end else begin
               in_frame_in = 1'b0;
               bytes_remaining_in = '0;
               res_valid = 1'b1;
               res.event_res = rfr_pkg::EV_FINISHED;
               res.source_addr = header_ff[0];
               res.dest_addr = header_ff[1];
               res.control_code = header_ff[2];
               res.function_code = header_ff[3];
               res.data_length = header_ff[4];
               res.checksum_ok = sum_ok;
               res.message_class = sum_ok ? rfr_pkg::classify(header_ff[2], header_ff[3])
                                          : rfr_pkg::CLASS_OTHER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         previous_byte_ff <= '0;
         bytes_taken_ff <= '0;
         bytes_remaining_ff <= '0;
         header_ff <= '{default: '0};
         running_sum_ff <= '0;
         sum_high_ff <= '0;
         idle_count_ff <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         previous_byte_ff <= previous_byte_in;
         bytes_taken_ff <= bytes_taken_in;
         bytes_remaining_ff <= bytes_remaining_in;
         header_ff <= header_in;
         running_sum_ff <= running_sum_in;
         sum_high_ff <= sum_high_in;
         idle_count_ff <= idle_count_in;
      end
   end

endmodule

[src/rfr_out_stage.sv]
module rfr_out_stage (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic res_valid,
   input  rfr_pkg::result_type res,
   output logic free,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rfr_pkg::result_type rsp_res
);

   logic valid_ff, valid_in;
   rfr_pkg::result_type res_ff, res_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      res_in = res_ff;
      if (advance) begin
         valid_in = res_valid;
         if (res_valid) begin
            res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res = res_ff;

endmodule

[src/rs485_frame_receiver_sum_check.sv]
// Receives a stream of words, each either a received byte or one time tick, finds frames
// that open with the pair 0xAA 0x55, and reports each payload byte with its index and each
// finished frame with its five header bytes, a checksum flag and a message class; an open
// frame that sees more idle ticks than csr_data last set (500 after reset) is reported as
// aborted. The block takes one word per cycle while no held result waits on rsp_ready;
// each accepted word passes its input register and then its result register, and words that
// cause no result leave nothing on the result channel.
module rs485_frame_receiver_sum_check (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic [7:0] rsp_source_addr,
   output logic [7:0] rsp_dest_addr,
   output logic [7:0] rsp_control_code,
   output logic [7:0] rsp_function_code,
   output logic [7:0] rsp_data_length,
   output logic rsp_checksum_ok,
   output logic [1:0] rsp_message_class,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0] timeout_ff, timeout_in;
   logic item_valid;
   rfr_pkg::item_type item;
   logic free;
   logic advance;
   logic res_valid;
   rfr_pkg::result_type res;
   rfr_pkg::result_type rsp_res;

   assign csr_ready = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= rfr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign advance = item_valid && free;

   rfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   rfr_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (item),
      .timeout_ticks (timeout_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   rfr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_event_res = rsp_res.event_res;
   assign rsp_payload_byte = rsp_res.payload_byte;
   assign rsp_payload_index = rsp_res.payload_index;
   assign rsp_source_addr = rsp_res.source_addr;
   assign rsp_dest_addr = rsp_res.dest_addr;
   assign rsp_control_code = rsp_res.control_code;
   assign rsp_function_code = rsp_res.function_code;
   assign rsp_data_length = rsp_res.data_length;
   assign rsp_checksum_ok = rsp_res.checksum_ok;
   assign rsp_message_class = rsp_res.message_class;

endmodule

[sim/rs485_frame_receiver_sum_check_tb.sv]
module rs485_frame_receiver_sum_check_tb;
   import rfr_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic [7:0] rsp_source_addr;
   logic [7:0] rsp_dest_addr;
   logic [7:0] rsp_control_code;
   logic [7:0] rsp_function_code;
   logic [7:0] rsp_data_length;
   logic rsp_checksum_ok;
   logic [1:0] rsp_message_class;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = 16'h0000;

   item_type pending_words[$];
   result_type expected_events[$];
   int queued_count = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   bit steady = 1'b1;
   int tick_odds = 0;
   int tick_max = 1;
   int burst_left = 0;
   int gap_left = 0;
   int stall_window = 0;
   int stall_mode = 0;
   logic [15:0] stall_lfsr = 16'hACE1;

   logic [15:0] timeout_limit = TIMEOUT_RESET;
   logic frame_open = 1'b0;
   logic [7:0] hunt_last = 8'h00;
   logic [8:0] taken_cnt = 9'd0;
   logic [8:0] due_cnt = 9'd0;
   logic [7:0] hdr [0:4] = '{default: 8'h00};
   logic [15:0] sum_acc = 16'h0000;
   logic [7:0] sum_hi = 8'h00;
   logic [15:0] idle_ticks = 16'h0000;

   rs485_frame_receiver_sum_check u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_source_addr(rsp_source_addr),
      .rsp_dest_addr(rsp_dest_addr),
      .rsp_control_code(rsp_control_code),
      .rsp_function_code(rsp_function_code),
      .rsp_data_length(rsp_data_length),
      .rsp_checksum_ok(rsp_checksum_ok),
      .rsp_message_class(rsp_message_class),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic class_type class_of(input logic [7:0] ctrl, input logic [7:0] func);
      case ({ctrl, func})
         {CTRL_REGISTER, FUNC_REG_REQUEST}: return CLASS_REG_REQUEST;
         {CTRL_REGISTER, FUNC_REG_CONFIRM}: return CLASS_REG_CONFIRM;
         {CTRL_INFO, FUNC_REG_CONFIRM}: return CLASS_INFO_REPLY;
         default: return CLASS_OTHER;
      endcase
   endfunction

   task automatic decode_word(input logic kind, input logic [7:0] b);
      result_type r;
      logic [16:0] next_idle;
      logic ok;
      r = '0;
      if (kind == KIND_TICK) begin
         if (frame_open) begin
            next_idle = {1'b0, idle_ticks} + 17'd1;
            if (next_idle > {1'b0, timeout_limit}) begin
               frame_open = 1'b0;
               idle_ticks = 16'h0000;
               r.event_res = EV_ABORTED;
               expected_events = {expected_events, r};
            end else begin
               idle_ticks = next_idle[15:0];
            end
         end
      end else begin
         idle_ticks = 16'h0000;
         if (!frame_open) begin
            if (hunt_last == START_FIRST && b == START_SECOND) begin
               frame_open = 1'b1;
               taken_cnt = 9'd0;
               due_cnt = 9'd0;
               hunt_last = 8'h00;
               sum_acc = START_SUM;
            end else begin
               hunt_last = b;
            end
         end else if (taken_cnt < HEADER_LEN) begin
            hdr[taken_cnt[2:0]] = b;
            sum_acc = sum_acc + {8'h00, b};
            taken_cnt = taken_cnt + 9'd1;
            if (taken_cnt == HEADER_LEN) begin
               due_cnt = 9'(b) + 9'd2;
            end
         end else if (due_cnt > 9'd2) begin
            r.event_res = EV_PAYLOAD;
            r.payload_byte = b;
            r.payload_index = 8'(taken_cnt - HEADER_LEN);
            sum_acc = sum_acc + {8'h00, b};
            taken_cnt = taken_cnt + 9'd1;
            due_cnt = due_cnt - 9'd1;
            expected_events = {expected_events, r};
         end else if (due_cnt == 9'd2) begin
            sum_hi = b;
            due_cnt = 9'd1;
         end else begin
            ok = (sum_hi == sum_acc[15:8]) && (b == sum_acc[7:0]);
            frame_open = 1'b0;
            due_cnt = 9'd0;
            r.event_res = EV_FINISHED;
            r.source_addr = hdr[0];
            r.dest_addr = hdr[1];
            r.control_code = hdr[2];
            r.function_code = hdr[3];
            r.data_length = hdr[4];
            r.checksum_ok = ok;
            r.message_class = ok ? class_of(hdr[2], hdr[3]) : CLASS_OTHER;
            expected_events = {expected_events, r};
         end
      end
   endtask

   task automatic report_event_mismatch(input string what, input result_type want,
                                        input result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected ev=%0d byte=%h idx=%0d hdr=%h %h %h %h %h ok=%b cls=%0d",
                  what, want.event_res, want.payload_byte, want.payload_index,
                  want.source_addr, want.dest_addr, want.control_code, want.function_code,
                  want.data_length, want.checksum_ok, want.message_class);
         $display("   actual ev=%0d byte=%h idx=%0d hdr=%h %h %h %h %h ok=%b cls=%0d",
                  got.event_res, got.payload_byte, got.payload_index,
                  got.source_addr, got.dest_addr, got.control_code, got.function_code,
                  got.data_length, got.checksum_ok, got.message_class);
      end
   endtask

   // The sender presents words in bursts with gaps between them unless steady is set; a held word is never changed.
   always @(posedge clock) begin : drive_words
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_word(pending_words[0].kind, pending_words[0].rx_byte);
            void'(pending_words.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            send = 1'b0;
            if (pending_words.size() != 0) begin
               if (gap_left > 0 && !steady) begin
                  gap_left--;
               end else begin
                  send = 1'b1;
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 32);
                     gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  end
               end
            end
            req_valid <= send;
            if (send) begin
               req_kind <= pending_words[0].kind;
               req_rx_byte <= pending_words[0].rx_byte;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_events
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.event_res = event_type'(rsp_event_res);
            got.payload_byte = rsp_payload_byte;
            got.payload_index = rsp_payload_index;
            got.source_addr = rsp_source_addr;
            got.dest_addr = rsp_dest_addr;
            got.control_code = rsp_control_code;
            got.function_code = rsp_function_code;
            got.data_length = rsp_data_length;
            got.checksum_ok = rsp_checksum_ok;
            got.message_class = class_type'(rsp_message_class);
            if (expected_events.size() == 0) begin
               report_event_mismatch("unexpected event", '0, got);
            end else begin
               want = expected_events.pop_front();
               if (got.event_res !== want.event_res ||
                   got.payload_byte !== want.payload_byte ||
                   got.payload_index !== want.payload_index ||
                   got.source_addr !== want.source_addr ||
                   got.dest_addr !== want.dest_addr ||
                   got.control_code !== want.control_code ||
                   got.function_code !== want.function_code ||
                   got.data_length !== want.data_length ||
                   got.checksum_ok !== want.checksum_ok ||
                   got.message_class !== want.message_class) begin
                  report_event_mismatch("event mismatch", want, got);
               end
            end
         end
         stall_lfsr = {stall_lfsr[14:0],
                       stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
         if (stall_window == 0) begin
            stall_window = $urandom_range(32, 256);
            stall_mode = $urandom_range(0, 3);
         end else begin
            stall_window--;
         end
         case (stall_mode)
            1: rsp_ready <= steady || (stall_lfsr[1:0] != 2'b00);
            2: rsp_ready <= steady || stall_lfsr[0];
            3: rsp_ready <= steady || (stall_lfsr[2:0] == 3'b000);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(input logic kind, input logic [7:0] b, input bit counted);
      item_type w;
      w.kind = kind;
      w.rx_byte = b;
      pending_words = {pending_words, w};
      if (counted) begin
         queued_count++;
      end
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_word(KIND_TICK, 8'($urandom), 1'b1);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic frame_byte(input logic [7:0] b);
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
         push_ticks($urandom_range(1, tick_max));
      end
      push_word(KIND_BYTE, b, 1'b1);
   endtask

   task automatic push_frame(input logic [7:0] ctrl, input logic [7:0] func,
                             input logic [7:0] len, input bit bad_sum, input int cut);
      logic [7:0] fb[$];
      logic [7:0] src;
      logic [7:0] dst;
      logic [7:0] b;
      logic [15:0] s;
      int n;
      src = pick_byte();
      dst = pick_byte();
      fb = {START_FIRST, START_SECOND, src, dst, ctrl, func, len};
      s = START_SUM + {8'h00, src} + {8'h00, dst} + {8'h00, ctrl} + {8'h00, func} +
          {8'h00, len};
      for (int i = 0; i < len; i++) begin
         b = pick_byte();
         fb = {fb, b};
         s = s + {8'h00, b};
      end
      if (bad_sum) begin
         s = s ^ 16'($urandom_range(1, 65535));
      end
      fb = {fb, s[15:8]};
      fb = {fb, s[7:0]};
      n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
      for (int i = 0; i < n; i++) begin
         frame_byte(fb[i]);
      end
   endtask

   task automatic random_frame();
      logic [7:0] ctrl;
      logic [7:0] func;
      logic [7:0] len;
      int cut;
      case ($urandom_range(0, 4))
         0: begin ctrl = CTRL_REGISTER; func = FUNC_REG_REQUEST; end
         1: begin ctrl = CTRL_REGISTER; func = FUNC_REG_CONFIRM; end
         2: begin ctrl = CTRL_INFO; func = FUNC_REG_CONFIRM; end
         3: begin ctrl = CTRL_INFO; func = FUNC_REG_REQUEST; end
         default: begin ctrl = pick_byte(); func = pick_byte(); end
      endcase
      len = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
      push_frame(ctrl, func, len, $urandom_range(0, 4) == 0, cut);
      if (cut != 0 && timeout_limit <= 16'd64) begin
         push_ticks(int'(timeout_limit) + 1);
      end
   endtask

   task automatic random_traffic(input int count);
      int start;
      start = queued_count;
      while (queued_count - start < count) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 7))
                  0: push_word(KIND_TICK, 8'($urandom), 1'b0);
                  1: begin
                     push_word(KIND_BYTE, START_FIRST, 1'b1);
                     push_word(KIND_BYTE, START_SECOND, 1'b1);
                  end
                  default: push_word(KIND_BYTE, pick_byte(), 1'b1);
               endcase
            end
         end else begin
            random_frame();
         end
      end
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_limit = value;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_word(KIND_TICK, 8'hFF, 1'b1);
      push_word(KIND_BYTE, START_SECOND, 1'b1);
      push_frame(CTRL_REGISTER, FUNC_REG_REQUEST, 8'd0, 1'b0, 0);
      push_word(KIND_BYTE, START_SECOND, 1'b1);
      push_word(KIND_BYTE, START_FIRST, 1'b1);
      push_frame(CTRL_REGISTER, FUNC_REG_CONFIRM, 8'd1, 1'b0, 0);
      push_frame(CTRL_INFO, FUNC_REG_CONFIRM, 8'd2, 1'b0, 0);
      push_frame(8'hFF, 8'h00, 8'd1, 1'b0, 0);
      push_frame(CTRL_REGISTER, FUNC_REG_REQUEST, 8'd1, 1'b1, 0);
      push_frame(CTRL_INFO, FUNC_REG_CONFIRM, 8'd3, 1'b0, 7);
      push_ticks(500);
      push_word(KIND_BYTE, 8'h00, 1'b1);
      push_ticks(501);
      settle();

      steady = 1'b0;
      tick_odds = 8;
      tick_max = 4;
      random_traffic(150);
      settle();

      write_timeout(16'd0);
      push_frame(CTRL_REGISTER, FUNC_REG_REQUEST, 8'd2, 1'b0, 7);
      push_ticks(1);
      push_frame(CTRL_REGISTER, FUNC_REG_REQUEST, 8'd2, 1'b0, 0);
      tick_odds = 12;
      tick_max = 2;
      random_traffic(150);
      settle();

      write_timeout(16'd1);
      tick_odds = 6;
      tick_max = 3;
      random_traffic(150);
      settle();

      write_timeout(16'hFFFF);
      push_frame(CTRL_INFO, FUNC_REG_CONFIRM, 8'd4, 1'b0, 7);
      push_ticks(40);
      push_word(KIND_BYTE, 8'hFF, 1'b1);
      tick_odds = 5;
      tick_max = 8;
      random_traffic(150);
      settle();

      write_timeout(16'($urandom_range(2, 40)));
      tick_odds = 4;
      tick_max = 12;
      random_traffic(150);
      settle();

      steady = 1'b1;
      write_timeout(16'd3);
      tick_odds = 6;
      tick_max = 4;
      random_traffic(150);
      settle();

      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
